[design/lcdb_pkg.sv]
`default_nettype none
package lcdb_pkg;

   localparam int MaxWidth   = 128;
   localparam int MaxPages   = 8;
   localparam int ColIdxW    = $clog2(MaxWidth);
   localparam int QueueDepth = 4;
   localparam int QPtrW      = $clog2(QueueDepth);
   localparam int QCountW    = $clog2(QueueDepth + 1);
   localparam int CfgIdxW    = 3;
   localparam int CfgDataW   = 8;

   localparam logic [7:0] CMD_COL_HI = 8'h10;
   localparam logic [7:0] CMD_PAGE   = 8'hB0;

   typedef enum logic [CfgIdxW-1:0] {
      CFG_X_COLUMN     = 3'd0,
      CFG_Y_ROW        = 3'd1,
      CFG_WIDTH_COLS   = 3'd2,
      CFG_HEIGHT_PAGES = 3'd3,
      CFG_PAGE_BANK    = 3'd4
   } cfg_index_type;

   // One queued column: optional page header plus the two display bytes.
   typedef struct packed {
      logic       hdr;
      logic [7:0] col_hi;
      logic [7:0] col_lo;
      logic [7:0] page;
      logic [7:0] data_lo;
      logic [7:0] data_hi;
      logic       done;
   } blit_op_type;

endpackage
`default_nettype wire

[design/lcdb_front.sv]
`default_nettype none
module lcdb_front (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [7:0]                       req_plane_lo,
   input  wire logic [7:0]                       req_plane_hi,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [lcdb_pkg::CfgIdxW-1:0]     csr_index,
   input  wire logic [lcdb_pkg::CfgDataW-1:0]    csr_data,
   output logic                                  push_valid,
   input  wire logic                             push_ready,
   output lcdb_pkg::blit_op_type                 push_op
);
   import lcdb_pkg::*;

   logic [6:0] x_column_ff;
   logic [5:0] y_row_ff;
   logic [7:0] width_cols_ff;
   logic [3:0] height_pages_ff;
   logic       page_bank_ff;

   logic [3:0] page_count_ff, page_count_in;
   logic [7:0] column_count_ff, column_count_in;

   logic [15:0] carry_mem [MaxWidth];
   logic [15:0] carry_rd_ff;

   logic       s1_valid_ff, s1_valid_in;
   logic       s1_hdr_ff, s1_first_ff, s1_last_ff, s1_done_ff;
   logic [7:0] s1_col_hi_ff, s1_col_lo_ff, s1_page_ff, s1_lo_ff, s1_hi_ff;
   logic [2:0] s1_sh_ff;

   logic              accept, push;
   logic [7:0]        w_eff;
   logic [3:0]        h_eff, total;
   logic [2:0]        sh;
   logic              col_last, page_last;
   logic [ColIdxW-1:0] col_idx;
   logic [3:0]        page_num;
   logic              keep_in, keep_prev;
   logic [7:0]        in_lo, in_hi, prev_lo, prev_hi;
   logic [15:0]       wide_lo, wide_hi;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_column_ff     <= '0;
         y_row_ff        <= '0;
         width_cols_ff   <= 8'd1;
         height_pages_ff <= 4'd1;
         page_bank_ff    <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            CFG_X_COLUMN:     x_column_ff     <= csr_data[6:0];
            CFG_Y_ROW:        y_row_ff        <= csr_data[5:0];
            CFG_WIDTH_COLS:   width_cols_ff   <= csr_data[7:0];
            CFG_HEIGHT_PAGES: height_pages_ff <= csr_data[3:0];
            CFG_PAGE_BANK:    page_bank_ff    <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign push      = s1_valid_ff && push_ready;
   assign req_ready = !s1_valid_ff || push_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      if (width_cols_ff == 8'd0) begin
         w_eff = 8'd1;
      end else if (width_cols_ff > 8'(MaxWidth)) begin
         w_eff = 8'(MaxWidth);
      end else begin
         w_eff = width_cols_ff;
      end
      if (height_pages_ff == 4'd0) begin
         h_eff = 4'd1;
      end else if (height_pages_ff > 4'(MaxPages)) begin
         h_eff = 4'(MaxPages);
      end else begin
         h_eff = height_pages_ff;
      end
      sh        = y_row_ff[2:0];
      total     = h_eff + {3'b0, (sh != 3'd0)};
      col_last  = ({1'b0, column_count_ff} + 9'd1) >= {1'b0, w_eff};
      page_last = ({1'b0, page_count_ff} + 5'd1) >= {1'b0, total};
      if (column_count_ff >= 8'(MaxWidth)) begin
         col_idx = ColIdxW'(MaxWidth - 1);
      end else begin
         col_idx = column_count_ff[ColIdxW-1:0];
      end
      page_num = {1'b0, y_row_ff[5:3]} + page_count_ff + {page_bank_ff, 3'b000};
   end

   always_comb begin
      page_count_in   = page_count_ff;
      column_count_in = column_count_ff;
      if (accept) begin
         if (col_last && page_last) begin
            page_count_in   = '0;
            column_count_in = '0;
         end else if (col_last) begin
            page_count_in   = page_count_ff + 4'd1;
            column_count_in = '0;
         end else begin
            column_count_in = column_count_ff + 8'd1;
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (push) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         page_count_ff   <= '0;
         column_count_ff <= '0;
         s1_valid_ff     <= 1'b0;
      end else begin
         page_count_ff   <= page_count_in;
         column_count_ff <= column_count_in;
         s1_valid_ff     <= s1_valid_in;
      end
   end

   // Read returns the entry as it was before this request's write.
   always_ff @(posedge clock) begin
      if (accept) begin
         carry_rd_ff       <= carry_mem[col_idx];
         carry_mem[col_idx] <= {req_plane_hi, req_plane_lo};
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_hdr_ff    <= (column_count_ff == 8'd0);
         s1_col_hi_ff <= CMD_COL_HI | {5'b0, x_column_ff[6:4]};
         s1_col_lo_ff <= {4'b0, x_column_ff[3:0]};
         s1_page_ff   <= CMD_PAGE | {4'b0, page_num};
         s1_lo_ff     <= req_plane_lo;
         s1_hi_ff     <= req_plane_hi;
         s1_sh_ff     <= sh;
         s1_first_ff  <= (page_count_ff == 4'd0);
         s1_last_ff   <= page_last;
         s1_done_ff   <= col_last && page_last;
      end
   end

   // Shifting {new, carried} left by the row offset leaves the merged byte on top.
   always_comb begin
      keep_prev = !s1_first_ff && (s1_sh_ff != 3'd0);
      keep_in   = s1_first_ff || !s1_last_ff || (s1_sh_ff == 3'd0);
      in_lo     = keep_in ? s1_lo_ff : 8'd0;
      in_hi     = keep_in ? s1_hi_ff : 8'd0;
      prev_lo   = keep_prev ? carry_rd_ff[7:0] : 8'd0;
      prev_hi   = keep_prev ? carry_rd_ff[15:8] : 8'd0;
      wide_lo   = {in_lo, prev_lo} << s1_sh_ff;
      wide_hi   = {in_hi, prev_hi} << s1_sh_ff;
      push_op.hdr     = s1_hdr_ff;
      push_op.col_hi  = s1_col_hi_ff;
      push_op.col_lo  = s1_col_lo_ff;
      push_op.page    = s1_page_ff;
      push_op.data_lo = wide_lo[15:8];
      push_op.data_hi = wide_hi[15:8];
      push_op.done    = s1_done_ff;
   end

   assign push_valid = s1_valid_ff;

endmodule
`default_nettype wire

[design/lcdb_queue.sv]
`default_nettype none
module lcdb_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push_valid,
   output logic                       push_ready,
   input  wire lcdb_pkg::blit_op_type push_op,
   output logic                       pop_valid,
   input  wire logic                  pop,
   output lcdb_pkg::blit_op_type      pop_op
);
   import lcdb_pkg::*;

   blit_op_type        entry_ff [QueueDepth];
   logic [QPtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCountW-1:0] count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready = (count_ff != QCountW'(QueueDepth));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;
   assign pop_op     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPtrW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPtrW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCountW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCountW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule
`default_nettype wire

[design/lcdb_back.sv]
`default_nettype none
module lcdb_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  pop_valid,
   output logic                       pop,
   input  wire lcdb_pkg::blit_op_type pop_op,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [7:0]                 rsp_out_byte,
   output logic                       rsp_is_data,
   output logic                       rsp_run_last,
   output logic                       rsp_blit_done
);
   import lcdb_pkg::*;

   typedef enum logic [4:0] {
      S_CMD_HI   = 5'b00001,
      S_CMD_LO   = 5'b00010,
      S_CMD_PAGE = 5'b00100,
      S_DATA_LO  = 5'b01000,
      S_DATA_HI  = 5'b10000
   } step_type;

   step_type   state_ff, state_in, cur;
   logic       load;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] byte_in;
   logic       is_data_in, last_in;
   logic [7:0] out_byte_ff;
   logic       is_data_ff, run_last_ff, blit_done_ff;

   assign load = pop_valid && (!rsp_valid_ff || rsp_ready);

   // A column without a page header starts directly at its data bytes.
   always_comb begin
      cur = state_ff;
      if (state_ff == S_CMD_HI && !pop_op.hdr) begin
         cur = S_DATA_LO;
      end
   end

   always_comb begin
      byte_in    = pop_op.data_hi;
      is_data_in = 1'b1;
      last_in    = 1'b0;
      state_in   = state_ff;
      case (cur)
         S_CMD_HI: begin
            byte_in    = pop_op.col_hi;
            is_data_in = 1'b0;
            state_in   = S_CMD_LO;
         end
         S_CMD_LO: begin
            byte_in    = pop_op.col_lo;
            is_data_in = 1'b0;
            state_in   = S_CMD_PAGE;
         end
         S_CMD_PAGE: begin
            byte_in    = pop_op.page;
            is_data_in = 1'b0;
            state_in   = S_DATA_LO;
         end
         S_DATA_LO: begin
            byte_in  = pop_op.data_lo;
            state_in = S_DATA_HI;
         end
         S_DATA_HI: begin
            byte_in  = pop_op.data_hi;
            last_in  = 1'b1;
            state_in = S_CMD_HI;
         end
         default: begin
            state_in = S_CMD_HI;
         end
      endcase
   end

   assign pop = load && last_in;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CMD_HI;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (load) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_byte_ff  <= byte_in;
         is_data_ff   <= is_data_in;
         run_last_ff  <= last_in;
         blit_done_ff <= last_in && pop_op.done;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = out_byte_ff;
   assign rsp_is_data   = is_data_ff;
   assign rsp_run_last  = run_last_ff;
   assign rsp_blit_done = blit_done_ff;

endmodule
`default_nettype wire

[design/page_lcd_blit_with_row_shift_top.sv]
// Page-addressed LCD blit for a 2-bit-per-pixel sprite.
// The req_ channel takes one sprite column per request (two plane bytes), page
// by page; when the start row is not page aligned, one extra trailing page of
// dummy requests flushes the carried bits. The rsp_ channel gives one byte per
// response: a three-byte page header (column high, column low, page) before the
// first column of each page, then two data bytes per column.
// The csr_ channel writes the five setup registers; write only while idle.
// An accepted request passes the line store read and stage register, the queue
// and the output register before its first byte appears.
// A column gives two output bytes, five when it carries a page header, so the
// output register's one byte per cycle, while the receiver is ready, sets the
// sustained request rate. A four-entry queue between the column front end
// and the byte sequencer absorbs headers and short receiver stalls; when the
// receiver stalls longer the queue fills and req_ready drops.
// Reset clears the counters, the queue and the setup registers; the line store
// needs no clearing because each page writes its columns before the next reads.
`default_nettype none
module page_lcd_blit_with_row_shift_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [7:0]                    req_plane_lo,
   input  wire logic [7:0]                    req_plane_hi,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [7:0]                         rsp_out_byte,
   output logic                               rsp_is_data,
   output logic                               rsp_run_last,
   output logic                               rsp_blit_done,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [lcdb_pkg::CfgIdxW-1:0]  csr_index,
   input  wire logic [lcdb_pkg::CfgDataW-1:0] csr_data
);
   import lcdb_pkg::*;

   logic        push_valid, push_ready, pop_valid, pop;
   blit_op_type push_op, pop_op;

   lcdb_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_plane_lo (req_plane_lo),
      .req_plane_hi (req_plane_hi),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .push_valid   (push_valid),
      .push_ready   (push_ready),
      .push_op      (push_op)
   );

   lcdb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_op    (push_op),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_op     (pop_op)
   );

   lcdb_back u_back (
      .clock         (clock),
      .reset         (reset),
      .pop_valid     (pop_valid),
      .pop           (pop),
      .pop_op        (pop_op),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_is_data   (rsp_is_data),
      .rsp_run_last  (rsp_run_last),
      .rsp_blit_done (rsp_blit_done)
   );

endmodule
`default_nettype wire

[tb/sv/page_lcd_blit_with_row_shift_top_test.sv]
`timescale 1ns / 1ps
module page_lcd_blit_with_row_shift_top_test;
   import lcdb_pkg::*;

   localparam int StallMax  = 18;
   localparam int QuietLimit = 2000;

   typedef struct packed {
      logic [7:0] value;
      logic       is_data;
      logic       run_last;
      logic       blit_done;
   } lcd_byte_type;

   typedef struct packed {
      logic [7:0] lo;
      logic [7:0] hi;
   } sprite_column_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                req_valid    = 1'b0;
   logic                req_ready;
   logic [7:0]          req_plane_lo = 8'h00;
   logic [7:0]          req_plane_hi = 8'h00;
   logic                rsp_valid;
   logic                rsp_ready    = 1'b0;
   logic [7:0]          rsp_out_byte;
   logic                rsp_is_data;
   logic                rsp_run_last;
   logic                rsp_blit_done;
   logic                csr_valid    = 1'b0;
   logic                csr_ready;
   logic [CfgIdxW-1:0]  csr_index    = '0;
   logic [CfgDataW-1:0] csr_data     = '0;

   page_lcd_blit_with_row_shift_top u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_plane_lo  (req_plane_lo),
      .req_plane_hi  (req_plane_hi),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_is_data   (rsp_is_data),
      .rsp_run_last  (rsp_run_last),
      .rsp_blit_done (rsp_blit_done),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Shadow copy of the setup registers and the blit state.
   logic [6:0]  cfg_x      = '0;
   logic [5:0]  cfg_y      = '0;
   logic [7:0]  cfg_width  = 8'd1;
   logic [3:0]  cfg_height = 4'd1;
   logic        cfg_bank   = 1'b0;
   logic [15:0] carry_mem [MaxWidth];
   int          page_cnt   = 0;
   int          col_cnt    = 0;

   sprite_column_type columns_to_send[$];
   lcd_byte_type      lcd_bytes_due[$];

   int   mismatches  = 0;
   int   req_gap     = 0;
   int   rsp_stall   = 0;
   int   quiet_count = 0;
   logic no_idle     = 1'b0;
   logic req_acc     = 1'b0;
   logic rsp_acc     = 1'b0;
   logic next_valid;

   function automatic int eff_width();
      if (cfg_width == 0) return 1;
      if (cfg_width > MaxWidth) return MaxWidth;
      return cfg_width;
   endfunction

   // Output pages of one blit, counting the trailing carry page.
   function automatic int eff_pages();
      int h;
      h = (cfg_height == 0) ? 1 : (cfg_height > MaxPages) ? MaxPages : cfg_height;
      return h + ((cfg_y[2:0] != 0) ? 1 : 0);
   endfunction

   task automatic predict_column(input logic [7:0] lo, input logic [7:0] hi);
      logic [2:0]  sh;
      logic [3:0]  page_no;
      logic [7:0]  v0, v1, p0, p1;
      logic [15:0] prev;
      int          col, total;
      logic        end_page, end_blit;
      sh    = cfg_y[2:0];
      total = eff_pages();
      if (col_cnt == 0) begin
         page_no = cfg_y[5:3] + page_cnt[3:0] + {cfg_bank, 3'b000};
         lcd_bytes_due.push_back('{value: CMD_COL_HI | {5'b0, cfg_x[6:4]},
                                   is_data: 1'b0, run_last: 1'b0, blit_done: 1'b0});
         lcd_bytes_due.push_back('{value: {4'b0, cfg_x[3:0]},
                                   is_data: 1'b0, run_last: 1'b0, blit_done: 1'b0});
         lcd_bytes_due.push_back('{value: CMD_PAGE | {4'b0, page_no},
                                   is_data: 1'b0, run_last: 1'b0, blit_done: 1'b0});
      end
      col = (col_cnt >= MaxWidth) ? MaxWidth - 1 : col_cnt;
      if (sh == 0) begin
         v0 = lo;
         v1 = hi;
      end else begin
         prev = carry_mem[col];
         p0   = prev[7:0];
         p1   = prev[15:8];
         if (page_cnt == 0) begin
            v0 = lo << sh;
            v1 = hi << sh;
         end else if (page_cnt + 1 >= total) begin
            v0 = p0 >> (8 - sh);
            v1 = p1 >> (8 - sh);
         end else begin
            v0 = (p0 >> (8 - sh)) | (lo << sh);
            v1 = (p1 >> (8 - sh)) | (hi << sh);
         end
      end
      carry_mem[col] = {hi, lo};
      end_page = (col_cnt + 1 >= eff_width());
      end_blit = end_page && (page_cnt + 1 >= total);
      lcd_bytes_due.push_back('{value: v0, is_data: 1'b1, run_last: 1'b0, blit_done: 1'b0});
      lcd_bytes_due.push_back('{value: v1, is_data: 1'b1, run_last: 1'b1,
                                blit_done: end_blit});
      if (end_blit) begin
         page_cnt = 0;
         col_cnt  = 0;
      end else if (end_page) begin
         page_cnt++;
         col_cnt = 0;
      end else begin
         col_cnt++;
      end
   endtask

   task automatic flag_mismatch(input string what);
      if (mismatches < 10) $display("%0t: %s", $realtime, what);
      mismatches++;
   endtask

   // Sample both channels at the rising edge, before the block updates.
   always @(posedge clock) begin
      lcd_byte_type due;
      req_acc <= !reset && req_valid && req_ready;
      rsp_acc <= !reset && rsp_valid && rsp_ready;
      if (!reset && rsp_valid && rsp_ready) begin
         if (lcd_bytes_due.size() == 0) begin
            flag_mismatch($sformatf("unexpected byte %02h data %b last %b done %b",
                                    rsp_out_byte, rsp_is_data, rsp_run_last,
                                    rsp_blit_done));
         end else begin
            due = lcd_bytes_due.pop_front();
            if (rsp_out_byte !== due.value || rsp_is_data !== due.is_data ||
                rsp_run_last !== due.run_last || rsp_blit_done !== due.blit_done) begin
               flag_mismatch($sformatf(
                  "expected byte %02h data %b last %b done %b, got %02h %b %b %b",
                  due.value, due.is_data, due.run_last, due.blit_done,
                  rsp_out_byte, rsp_is_data, rsp_run_last, rsp_blit_done));
            end
         end
      end
      if (!reset && req_valid && req_ready) predict_column(req_plane_lo, req_plane_hi);
   end

   always @(negedge clock) begin
      if (!reset) begin
         next_valid = req_valid;
         if (req_acc) begin
            void'(columns_to_send.pop_front());
            next_valid = 1'b0;
            req_gap = no_idle ? 0 : int'($urandom_range(0, StallMax));
         end
         if (!next_valid) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (columns_to_send.size() > 0) begin
               next_valid = 1'b1;
               req_plane_lo <= columns_to_send[0].lo;
               req_plane_hi <= columns_to_send[0].hi;
            end
         end
         req_valid <= next_valid;
      end
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_acc) rsp_stall = no_idle ? 0 : int'($urandom_range(0, StallMax));
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         quiet_count <= 0;
      else
         quiet_count <= quiet_count + 1;
      if (quiet_count >= QuietLimit) begin
         $display("page_lcd_blit_with_row_shift_top test failed");
         $finish;
      end
   end

   task automatic write_csr(input cfg_index_type idx, input logic [7:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CFG_X_COLUMN:     cfg_x      = value[6:0];
         CFG_Y_ROW:        cfg_y      = value[5:0];
         CFG_WIDTH_COLS:   cfg_width  = value;
         CFG_HEIGHT_PAGES: cfg_height = value[3:0];
         CFG_PAGE_BANK:    cfg_bank   = value[0];
         default: ;
      endcase
   endtask

   task automatic drain();
      while (columns_to_send.size() != 0 || lcd_bytes_due.size() != 0) @(posedge clock);
   endtask

   task automatic queue_columns(input int count, input bit patterned);
      logic [7:0] patt [4];
      patt = '{8'h00, 8'hFF, 8'h0F, 8'hF0};
      for (int k = 0; k < count; k++) begin
         if (patterned)
            columns_to_send.push_back('{lo: patt[k % 4], hi: patt[(k + 1) % 4]});
         else
            columns_to_send.push_back('{lo: 8'($urandom_range(0, 255)),
                                        hi: 8'($urandom_range(0, 255))});
      end
   endtask

   // Set up the registers and send the given number of blits whole, so the line
   // store is always filled by page zero before any later page reads it.
   task automatic run_blits(input logic [7:0] x, input logic [7:0] y, input logic [7:0] w,
                            input logic [7:0] h, input logic [7:0] bank, input int blits,
                            input bit patterned, input bit pause_midway, output int sent);
      int count;
      drain();
      repeat (4) @(posedge clock);
      write_csr(CFG_X_COLUMN, x);
      write_csr(CFG_Y_ROW, y);
      write_csr(CFG_WIDTH_COLS, w);
      write_csr(CFG_HEIGHT_PAGES, h);
      write_csr(CFG_PAGE_BANK, bank);
      @(negedge clock);
      csr_valid <= 1'b0;
      no_idle = ($urandom_range(0, 3) == 0);
      count = eff_width() * eff_pages() * blits;
      sent  = count;
      if (pause_midway && count > 1) begin
         // Hold back the second half until every byte so far has come out.
         queue_columns(count / 2, patterned);
         drain();
         queue_columns(count - count / 2, patterned);
      end else begin
         queue_columns(count, patterned);
      end
   endtask

   initial begin
      int sent, random_sent;
      logic [7:0] w, h;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      run_blits(8'd0, 8'd0, 8'd1, 8'd1, 8'd0, 3, 1'b1, 1'b0, sent);
      // Last page plus bank wraps past page fifteen.
      run_blits(8'd127, 8'd63, 8'd2, 8'd1, 8'd1, 1, 1'b1, 1'b0, sent);
      run_blits(8'hD5, 8'hC8, 8'd0, 8'd0, 8'hFE, 1, 1'b1, 1'b0, sent);
      run_blits(8'h2A, 8'd11, 8'd1, 8'd15, 8'd1, 1, 1'b1, 1'b0, sent);
      run_blits(8'd5, 8'd36, 8'd3, 8'd2, 8'd0, 1, 1'b0, 1'b0, sent);

      random_sent = 0;
      while (random_sent < 30) begin
         case ($urandom_range(0, 9))
            0:       w = 8'd0;
            default: w = 8'($urandom_range(1, 6));
         endcase
         case ($urandom_range(0, 9))
            0:       h = 8'd0;
            1:       h = 8'($urandom_range(9, 15) | ($urandom_range(0, 15) << 4));
            default: h = 8'($urandom_range(1, 3) | ($urandom_range(0, 15) << 4));
         endcase
         run_blits(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), w, h,
                   8'($urandom_range(0, 255)), int'($urandom_range(1, 2)), 1'b0,
                   random_sent == 0, sent);
         random_sent += sent;
      end
      // Oversized width clamps to the full line.
      run_blits(8'($urandom_range(0, 255)), 8'd16, 8'($urandom_range(129, 255)), 8'd1,
                8'($urandom_range(0, 255)), 1, 1'b0, 1'b0, sent);

      drain();
      repeat (20) @(posedge clock);
      if (lcd_bytes_due.size() != 0)
         flag_mismatch($sformatf("%0d expected bytes never came", lcd_bytes_due.size()));
      if (mismatches == 0) begin
         $display("page_lcd_blit_with_row_shift_top test passed");
      end else begin
         $display("page_lcd_blit_with_row_shift_top test failed");
      end
      $finish;
   end

endmodule
